### design/fmenc_pkg.sv
// shared types, constants and lookup functions for the fm channel command encoder
`default_nettype none

package fmenc_pkg;

   localparam int NUM_CHANNELS    = 9;
   localparam int NUM_INSTRUMENTS = 5;
   localparam int STORED_CHANNELS = 9;
   localparam int TABLE_ENTRIES   = 5;
   localparam int INSTR_WRITES    = 11;
   localparam int OP_REGS         = 5;

   localparam int CH_LIMIT  = (NUM_CHANNELS < STORED_CHANNELS) ? NUM_CHANNELS : STORED_CHANNELS;
   localparam int INS_LIMIT = (NUM_INSTRUMENTS < TABLE_ENTRIES) ? NUM_INSTRUMENTS : TABLE_ENTRIES;

   localparam int ACTION_W = 2;
   localparam int CHAN_W   = 4;
   localparam int FREQ_W   = 14;
   localparam int INS_W    = 3;
   localparam int OFF_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 5;
   localparam int BLOCK_W  = 3;
   localparam int FNUM_W   = 10;
   localparam int STEP_W   = 4;

   localparam logic [ACTION_W-1:0] ACT_KEY_ON     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_KEY_OFF    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SET_INSTR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SET_VOLUME = 2'd3;

   localparam logic [BYTE_W-1:0] REG_FNUM_LO = 8'hA0;
   localparam logic [BYTE_W-1:0] REG_KEY_BLK = 8'hB0;
   localparam logic [BYTE_W-1:0] REG_FB_CONN = 8'hC0;
   localparam logic [BYTE_W-1:0] REG_LEVEL   = 8'h40;
   localparam logic [OFF_W-1:0]  LEVEL_MASK  = 6'h3f;

   // fnum = floor(f * 2^(18-block) / 12429), the factor four of 49716 taken out
   localparam int PRE_SHIFT  = 18;
   localparam int SHIFT_W    = 5;
   localparam int Y_W        = 25;
   localparam int MAGIC_W    = 26;
   localparam int PROD_W     = Y_W + MAGIC_W;
   localparam int FNUM_SHIFT = 39;
   localparam logic [MAGIC_W-1:0] FNUM_MAGIC = 26'd44231702;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FREQ_W-1:0] BLOCK_LIMIT [0:7] = '{
      14'd48, 14'd97, 14'd194, 14'd388, 14'd776, 14'd1552, 14'd3104, 14'd6208
   };

   localparam logic [BYTE_W-1:0] OP_BASE [0:OP_REGS-1] = '{
      8'h20, 8'h40, 8'h60, 8'h80, 8'hE0
   };

   // op1 regs 20,40,60,80,e0 then op2 the same, then c0
   localparam logic [BYTE_W-1:0] INSTR_TAB [0:TABLE_ENTRIES-1][0:INSTR_WRITES-1] = '{
      '{8'h20, 8'h04, 8'hF0, 8'h0F, 8'h00, 8'h28, 8'h00, 8'hF0, 8'h0F, 8'h03, 8'h0A},
      '{8'h22, 8'h9A, 8'hF0, 8'h0F, 8'h00, 8'h21, 8'h00, 8'hF0, 8'h0F, 8'h00, 8'h0E},
      '{8'h22, 8'h96, 8'hF0, 8'h0F, 8'h00, 8'h21, 8'h00, 8'hF0, 8'h0F, 8'h00, 8'h0E},
      '{8'h20, 8'h1A, 8'hF2, 8'hF0, 8'h03, 8'h21, 8'h00, 8'hB4, 8'h18, 8'h00, 8'h0A},
      '{8'h10, 8'h0C, 8'hF0, 8'h08, 8'h00, 8'h1F, 8'h00, 8'hD8, 8'hF8, 8'h00, 8'h04}
   };

   localparam logic [STEP_W-1:0] STEP_VOLUME_BYTE = 4'd6;
   localparam logic [STEP_W-1:0] STEP_OP2_FIRST   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CONN        = 4'd10;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CHAN_W-1:0]   channel;
      logic [OP_W-1:0]     op1;
      logic [INS_W-1:0]    instrument;
      logic [OFF_W-1:0]    level_offset;
      logic [BLOCK_W-1:0]  block;
      logic [FNUM_W-1:0]   fnum;
   } cmd_type;

   function automatic logic [BLOCK_W-1:0] block_of(input logic [FREQ_W-1:0] f);
      logic [BLOCK_W-1:0] b;
      b = 3'd7;
      for (int i = 7; i >= 0; i--) begin
         if (f < BLOCK_LIMIT[i]) begin
            b = 3'(i);
         end
      end
      return b;
   endfunction

   function automatic logic [OP_W-1:0] op1_of(input logic [CHAN_W-1:0] ch);
      logic [OP_W-1:0] op;
      case (ch)
         4'd0:    op = 5'd0;
         4'd1:    op = 5'd1;
         4'd2:    op = 5'd2;
         4'd3:    op = 5'd8;
         4'd4:    op = 5'd9;
         4'd5:    op = 5'd10;
         4'd6:    op = 5'd16;
         4'd7:    op = 5'd17;
         4'd8:    op = 5'd18;
         default: op = 5'd0;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

### design/fmenc_if.sv
// handshake channel interfaces for commands and register writes
`default_nettype none

interface fmenc_req_if;
   logic                           valid;
   logic                           ready;
   logic [fmenc_pkg::ACTION_W-1:0] action;
   logic [fmenc_pkg::CHAN_W-1:0]   channel;
   logic [fmenc_pkg::FREQ_W-1:0]   freq;
   logic [fmenc_pkg::INS_W-1:0]    instrument;
   logic [fmenc_pkg::OFF_W-1:0]    level_offset;

   modport source (output valid, action, channel, freq, instrument, level_offset,
                   input ready);
   modport sink   (input valid, action, channel, freq, instrument, level_offset,
                   output ready);
endinterface

interface fmenc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fmenc_pkg::BYTE_W-1:0] reg_addr;
   logic [fmenc_pkg::BYTE_W-1:0] reg_data;
   logic                         last;

   modport source (output valid, reg_addr, reg_data, last, input ready);
   modport sink   (input valid, reg_addr, reg_data, last, output ready);
endinterface

`default_nettype wire

### design/fmenc_front.sv
// front end: accepts commands, drops bad ones, keeps note frequencies, derives block and fnum
`default_nettype none

module fmenc_front (
   input  wire logic       clock,
   input  wire logic       reset,
   fmenc_req_if.sink       req_port,
   output fmenc_pkg::cmd_type cmd_data,
   output logic            cmd_valid,
   input  wire logic       cmd_ready
);

   logic                                pipe_en;
   logic                                accept;
   logic                                ch_ok;
   logic                                ins_ok;
   logic                                keep;
   logic [fmenc_pkg::FREQ_W-1:0]        stored_rd;
   logic [fmenc_pkg::FREQ_W-1:0]        freq_sel;
   logic [fmenc_pkg::BLOCK_W-1:0]       blk;
   logic [fmenc_pkg::Y_W-1:0]           y_in;
   logic [fmenc_pkg::PROD_W-1:0]        prod;

   logic [fmenc_pkg::FREQ_W-1:0]        channel_freq_ff [0:fmenc_pkg::STORED_CHANNELS-1];
   logic                                v1_ff, v2_ff, v3_ff;
   fmenc_pkg::cmd_type                  cmd1_in, cmd1_ff, cmd2_in, cmd2_ff, cmd3_in, cmd3_ff;
   logic [fmenc_pkg::FREQ_W-1:0]        freq1_ff;
   logic [fmenc_pkg::Y_W-1:0]           y2_ff;

   assign pipe_en        = !v3_ff || cmd_ready;
   assign req_port.ready = pipe_en && !reset;
   assign accept         = req_port.valid && req_port.ready;

   assign ch_ok  = req_port.channel < fmenc_pkg::CHAN_W'(fmenc_pkg::CH_LIMIT);
   assign ins_ok = req_port.instrument < fmenc_pkg::INS_W'(fmenc_pkg::INS_LIMIT);
   assign keep   = ch_ok && (req_port.action == fmenc_pkg::ACT_KEY_ON ||
                             req_port.action == fmenc_pkg::ACT_KEY_OFF || ins_ok);

   always_comb begin
      stored_rd = '0;
      for (int i = 0; i < fmenc_pkg::STORED_CHANNELS; i++) begin
         if (req_port.channel == fmenc_pkg::CHAN_W'(i)) begin
            stored_rd = channel_freq_ff[i];
         end
      end
   end

   assign freq_sel = (req_port.action == fmenc_pkg::ACT_KEY_ON) ? req_port.freq : stored_rd;

   always_comb begin
      cmd1_in              = '0;
      cmd1_in.action       = req_port.action;
      cmd1_in.channel      = req_port.channel;
      cmd1_in.op1          = fmenc_pkg::op1_of(req_port.channel);
      cmd1_in.instrument   = req_port.instrument;
      cmd1_in.level_offset = req_port.level_offset;
   end

   // octave block and pre-scaled frequency
   assign blk = fmenc_pkg::block_of(freq1_ff);
   assign y_in = fmenc_pkg::Y_W'(freq1_ff) <<
                 (fmenc_pkg::SHIFT_W'(fmenc_pkg::PRE_SHIFT) - fmenc_pkg::SHIFT_W'(blk));

   always_comb begin
      cmd2_in       = cmd1_ff;
      cmd2_in.block = blk;
   end

   // reciprocal multiply, exact for every pre-scaled value
   assign prod = fmenc_pkg::PROD_W'(y2_ff) * fmenc_pkg::PROD_W'(fmenc_pkg::FNUM_MAGIC);

   always_comb begin
      cmd3_in      = cmd2_ff;
      cmd3_in.fnum = prod[fmenc_pkg::FNUM_SHIFT +: fmenc_pkg::FNUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i < fmenc_pkg::STORED_CHANNELS; i++) begin
            channel_freq_ff[i] <= '0;
         end
      end else begin
         if (pipe_en) begin
            v1_ff <= accept && keep;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         for (int i = 0; i < fmenc_pkg::STORED_CHANNELS; i++) begin
            if (accept && ch_ok && req_port.action == fmenc_pkg::ACT_KEY_ON &&
                req_port.channel == fmenc_pkg::CHAN_W'(i)) begin
               channel_freq_ff[i] <= req_port.freq;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cmd1_ff  <= cmd1_in;
         freq1_ff <= freq_sel;
         cmd2_ff  <= cmd2_in;
         y2_ff    <= y_in;
         cmd3_ff  <= cmd3_in;
      end
   end

   assign cmd_valid = v3_ff;
   assign cmd_data  = cmd3_ff;

endmodule

`default_nettype wire

### design/fmenc_queue.sv
// short command queue between front end and write sequencer
`default_nettype none

module fmenc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire fmenc_pkg::cmd_type push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output fmenc_pkg::cmd_type      pop_data
);

   fmenc_pkg::cmd_type              entries_ff [0:fmenc_pkg::QUEUE_DEPTH-1];
   logic [fmenc_pkg::QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [fmenc_pkg::QCNT_W-1:0]    count_ff;
   logic                            do_push, do_pop;

   assign push_ready = count_ff != fmenc_pkg::QCNT_W'(fmenc_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [fmenc_pkg::QPTR_W-1:0] wrap_inc(
      input logic [fmenc_pkg::QPTR_W-1:0] p);
      logic [fmenc_pkg::QPTR_W-1:0] n;
      if (p == fmenc_pkg::QPTR_W'(fmenc_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### design/fmenc_back.sv
// write sequencer: expands one queued command into register writes
`default_nettype none

module fmenc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire fmenc_pkg::cmd_type cmd_data,
   fmenc_rsp_if.source             rsp_port
);

   logic                           cur_valid_ff;
   fmenc_pkg::cmd_type             cur_ff;
   logic [fmenc_pkg::STEP_W-1:0]   step_ff;
   logic                           rsp_valid_ff;
   logic [fmenc_pkg::BYTE_W-1:0]   rsp_addr_ff, rsp_data_ff;
   logic                           rsp_last_ff;

   logic                           out_free, emit, load;
   logic [fmenc_pkg::BYTE_W-1:0]   w_addr, w_data, lvl;
   logic                           w_last;
   logic [fmenc_pkg::OP_W-1:0]     op2;
   logic [2:0]                     base_idx;
   logic [fmenc_pkg::OFF_W-1:0]    ol;

   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign emit      = cur_valid_ff && out_free;
   assign load      = !cur_valid_ff || (emit && w_last);
   assign cmd_ready = load;

   assign op2      = cur_ff.op1 + 5'd3;
   assign base_idx = (step_ff < fmenc_pkg::STEP_OP2_FIRST) ? step_ff[2:0] :
                     3'(step_ff - fmenc_pkg::STEP_OP2_FIRST);
   assign lvl      = fmenc_pkg::INSTR_TAB[cur_ff.instrument][fmenc_pkg::STEP_VOLUME_BYTE];
   assign ol       = (lvl[fmenc_pkg::OFF_W-1:0] + cur_ff.level_offset) & fmenc_pkg::LEVEL_MASK;

   always_comb begin
      w_addr = '0;
      w_data = '0;
      w_last = 1'b0;
      unique case (cur_ff.action) inside
         fmenc_pkg::ACT_KEY_ON, fmenc_pkg::ACT_KEY_OFF: begin
            if (step_ff == '0) begin
               w_addr = fmenc_pkg::REG_FNUM_LO + fmenc_pkg::BYTE_W'(cur_ff.channel);
               w_data = cur_ff.fnum[7:0];
            end else begin
               w_addr = fmenc_pkg::REG_KEY_BLK + fmenc_pkg::BYTE_W'(cur_ff.channel);
               w_data = {2'b00, cur_ff.action == fmenc_pkg::ACT_KEY_ON, cur_ff.block,
                         cur_ff.fnum[9:8]};
               w_last = 1'b1;
            end
         end
         fmenc_pkg::ACT_SET_INSTR: begin
            w_data = fmenc_pkg::INSTR_TAB[cur_ff.instrument][step_ff];
            if (step_ff < fmenc_pkg::STEP_OP2_FIRST) begin
               w_addr = fmenc_pkg::OP_BASE[base_idx] + fmenc_pkg::BYTE_W'(cur_ff.op1);
            end else if (step_ff < fmenc_pkg::STEP_CONN) begin
               w_addr = fmenc_pkg::OP_BASE[base_idx] + fmenc_pkg::BYTE_W'(op2);
            end else begin
               w_addr = fmenc_pkg::REG_FB_CONN + fmenc_pkg::BYTE_W'(cur_ff.channel);
               w_last = 1'b1;
            end
         end
         fmenc_pkg::ACT_SET_VOLUME: begin
            w_addr = fmenc_pkg::REG_LEVEL + fmenc_pkg::BYTE_W'(op2);
            w_data = {lvl[7:6], ol};
            w_last = 1'b1;
         end
         default: begin
            w_last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (load) begin
            cur_valid_ff <= cmd_valid;
            step_ff      <= '0;
         end else if (emit) begin
            step_ff <= step_ff + 1'b1;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= cmd_data;
      end
      if (emit) begin
         rsp_addr_ff <= w_addr;
         rsp_data_ff <= w_data;
         rsp_last_ff <= w_last;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.reg_addr = rsp_addr_ff;
   assign rsp_port.reg_data = rsp_data_ff;
   assign rsp_port.last     = rsp_last_ff;

endmodule

`default_nettype wire

### design/fm_synth_channel_command_encoder_top.sv
// top level of the fm channel command encoder
//
//  port      dir  transfer                 payload
//  req_port  in   one channel command      action, channel, freq, instrument, level_offset
//  rsp_port  out  one register write       reg_addr, reg_data, last
//
//  a command can be taken every cycle unless the sequencer or output stalls; the sequencer
//  emits one write per cycle while rsp ready: 2 for key on/off, 11 for set instrument,
//  1 for set volume, none for a bad channel or, on set instrument/volume, bad instrument
//  first write passes 3 front stages, queue, sequencer command reg and output reg
//  synchronous reset clears stored frequencies, queue and all valid flags
//  output stalls back up through the 2-entry queue into the front pipeline and req ready
`default_nettype none

module fm_synth_channel_command_encoder_top (
   input wire logic    clock,
   input wire logic    reset,
   fmenc_req_if.sink   req_port,
   fmenc_rsp_if.source rsp_port
);

   fmenc_pkg::cmd_type front_data, queue_data;
   logic               front_valid, front_ready;
   logic               queue_valid, queue_ready;

   fmenc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .cmd_data  (front_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   fmenc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data)
   );

   fmenc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_data),
      .rsp_port  (rsp_port)
   );

endmodule

`default_nettype wire

### design/fmenc_checker.sv
// port-level checks on the register write stream, bound to the top level
`default_nettype none

module fmenc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [fmenc_pkg::BYTE_W-1:0] rsp_reg_addr,
   input wire logic [fmenc_pkg::BYTE_W-1:0] rsp_reg_data,
   input wire logic                         rsp_last
);

   // no write is offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("write offered right after reset");

   // a stalled write holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg_addr) &&
                                  $stable(rsp_reg_data) && $stable(rsp_last))
      else $error("stalled write changed");

   // fnum low write always has its key/block write after it
   a_fnum_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_addr[7:4] == 4'hA |-> !rsp_last)
      else $error("fnum low write flagged last");

   // a sequence only ends on key/block, connection or level registers
   a_last_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_reg_addr[7:4] == 4'hB || rsp_reg_addr[7:4] == 4'hC ||
                                rsp_reg_addr[7:4] == 4'h4 || rsp_reg_addr[7:4] == 4'h5)
      else $error("sequence ended on unexpected register");

endmodule

bind fm_synth_channel_command_encoder_top fmenc_checker u_fmenc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .rsp_reg_addr (rsp_port.reg_addr),
   .rsp_reg_data (rsp_port.reg_data),
   .rsp_last     (rsp_port.last)
);

`default_nettype wire
